/* hdl/mseu_pkg.sv */
`default_nettype none

package mseu_pkg;

    localparam int DATA_W       = 32;
    localparam int IDX_W        = 5;
    localparam int ACT_W        = 5;
    localparam int NUM_REGS_DEF = 32;

    typedef logic [ACT_W-1:0] action_t;

    localparam action_t ACT_LI     = 5'd0;
    localparam action_t ACT_ADD    = 5'd1;
    localparam action_t ACT_SUB    = 5'd2;
    localparam action_t ACT_ADDI   = 5'd3;
    localparam action_t ACT_ADDU   = 5'd4;
    localparam action_t ACT_ADDIU  = 5'd5;
    localparam action_t ACT_SUBU   = 5'd6;
    localparam action_t ACT_MUL    = 5'd7;
    localparam action_t ACT_MULT   = 5'd8;
    localparam action_t ACT_DIV    = 5'd9;
    localparam action_t ACT_AND    = 5'd10;
    localparam action_t ACT_OR_REG = 5'd11;
    localparam action_t ACT_OR_IMM = 5'd12;
    localparam action_t ACT_ANDI   = 5'd13;
    localparam action_t ACT_SLL    = 5'd14;
    localparam action_t ACT_SRL    = 5'd15;
    localparam action_t ACT_XOR    = 5'd16;
    localparam action_t ACT_DUMP   = 5'd17;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_ctrl_t;

    typedef struct packed {
        logic busy;
    } md_stat_t;

endpackage

`default_nettype wire

/* hdl/mips_subset_execute_unit.sv */
`default_nettype none
// A register-file operation latches its operands, then registers its result once the output is free.
// mul, mult and div with a nonzero divisor run 32 steps through one shared add/subtract unit.
// A dump reads and then presents each register in turn, from index 0 up to NUM_REGS - 1.
// One request is in flight at a time; the next is accepted the cycle after the last result.
// Reset clears the register-file valid bits, hi and lo at once, so no clearing pass is needed.

module mips_subset_execute_unit #(
    parameter int NUM_REGS = mseu_pkg::NUM_REGS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mseu_pkg::ACT_W-1:0]     action,
    input  wire logic [mseu_pkg::IDX_W-1:0]     dest_index,
    input  wire logic [mseu_pkg::IDX_W-1:0]     src_a_index,
    input  wire logic [mseu_pkg::IDX_W-1:0]     src_b_index,
    input  wire logic signed [mseu_pkg::DATA_W-1:0] immediate,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [mseu_pkg::IDX_W-1:0]     result_index,
    output logic signed [mseu_pkg::DATA_W-1:0]  result_value,
    output logic                                wrote_register,
    output logic signed [mseu_pkg::DATA_W-1:0]  hi_value,
    output logic signed [mseu_pkg::DATA_W-1:0]  lo_value,
    output logic                                divide_by_zero,
    output logic                                last
);

    localparam int DW = mseu_pkg::DATA_W;
    localparam int IW = mseu_pkg::IDX_W;
    localparam int AW = $clog2(NUM_REGS);
    localparam logic [IW:0]   NREG_L    = (IW + 1)'(NUM_REGS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_REGS - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_MDWAIT   = 3'd2;
    localparam logic [2:0] S_DUMP_RD  = 3'd3;
    localparam logic [2:0] S_DUMP_OUT = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    logic [DW-1:0] rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic          rf_wr_en;
    logic [AW-1:0] rf_wr_addr;
    logic [DW-1:0] rf_wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_a_addr;
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;
    logic          a_ok_reg;
    logic          b_ok_reg;

    mseu_pkg::action_t act_reg;
    logic [IW-1:0] dest_reg;
    logic [DW-1:0] imm_reg;
    logic [DW-1:0] hi_reg;
    logic [DW-1:0] hi_next;
    logic [DW-1:0] lo_reg;
    logic [DW-1:0] lo_next;

    logic          out_valid_reg;
    logic [IW-1:0] res_index_reg;
    logic [DW-1:0] res_value_reg;
    logic          res_wrote_reg;
    logic [DW-1:0] res_hi_reg;
    logic [DW-1:0] res_lo_reg;
    logic          res_dz_reg;
    logic          res_last_reg;

    logic          emit;
    logic [IW-1:0] emit_index;
    logic [DW-1:0] emit_value;
    logic          emit_wrote;
    logic          emit_dz;
    logic          emit_last;

    logic          in_accept;
    logic          out_free;
    logic [DW-1:0] a_val;
    logic [DW-1:0] b_val;
    logic [DW-1:0] alu_val;
    logic          alu_writes;
    logic          dest_ok;
    logic          is_md;
    logic          div_zero;

    mseu_pkg::md_ctrl_t md_ctrl;
    mseu_pkg::md_stat_t md_stat;
    logic [DW-1:0]      md_hi;
    logic [DW-1:0]      md_lo;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign a_val   = a_ok_reg ? rd_a_reg : '0;
    assign b_val   = b_ok_reg ? rd_b_reg : '0;
    assign dest_ok = ({1'b0, dest_reg} < NREG_L);

    assign rd_en     = in_accept || (state_reg == S_DUMP_RD);
    assign rd_a_addr = (state_reg == S_DUMP_RD) ? cnt_reg : src_a_index[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (rf_wr_en)
        begin
            rf_mem[rf_wr_addr] <= rf_wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= rf_mem[rd_a_addr];
            rd_b_reg <= rf_mem[src_b_index[AW-1:0]];
        end
    end

    always_comb
    begin
        alu_val    = '0;
        alu_writes = 1'b1;
        unique case (act_reg)
            mseu_pkg::ACT_LI:     alu_val = imm_reg;
            mseu_pkg::ACT_ADD,
            mseu_pkg::ACT_ADDU:   alu_val = a_val + b_val;
            mseu_pkg::ACT_SUB,
            mseu_pkg::ACT_SUBU:   alu_val = a_val - b_val;
            mseu_pkg::ACT_ADDI,
            mseu_pkg::ACT_ADDIU:  alu_val = a_val + imm_reg;
            mseu_pkg::ACT_MUL:    alu_val = md_lo;
            mseu_pkg::ACT_AND:    alu_val = a_val & b_val;
            mseu_pkg::ACT_OR_REG: alu_val = a_val | b_val;
            mseu_pkg::ACT_OR_IMM: alu_val = a_val | imm_reg;
            mseu_pkg::ACT_ANDI:   alu_val = a_val & imm_reg;
            mseu_pkg::ACT_SLL:    alu_val = a_val << imm_reg[4:0];
            mseu_pkg::ACT_SRL:    alu_val = a_val >> imm_reg[4:0];
            mseu_pkg::ACT_XOR:    alu_val = a_val ^ b_val;
            default:              alu_writes = 1'b0;
        endcase
    end

    assign is_md    = (act_reg == mseu_pkg::ACT_MUL) || (act_reg == mseu_pkg::ACT_MULT)
                   || (act_reg == mseu_pkg::ACT_DIV);
    assign div_zero = (act_reg == mseu_pkg::ACT_DIV) && (b_val == '0);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        md_ctrl.start  = 1'b0;
        md_ctrl.is_div = (act_reg == mseu_pkg::ACT_DIV);
        emit           = 1'b0;
        emit_index     = '0;
        emit_value     = '0;
        emit_wrote     = 1'b0;
        emit_dz        = 1'b0;
        emit_last      = 1'b1;
        rf_wr_en       = 1'b0;
        rf_wr_addr     = dest_reg[AW-1:0];
        rf_wr_data     = alu_val;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (act_reg == mseu_pkg::ACT_DUMP)
                begin
                    state_next = S_DUMP_RD;
                    cnt_next   = '0;
                end
                else if (is_md && !div_zero)
                begin
                    md_ctrl.start = 1'b1;
                    state_next    = S_MDWAIT;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_dz    = div_zero;
                    state_next = S_IDLE;
                    if (alu_writes)
                    begin
                        emit_index = dest_reg;
                        emit_value = alu_val;
                        emit_wrote = dest_ok;
                        rf_wr_en   = dest_ok;
                    end
                end
            end
            S_MDWAIT:
            begin
                if (!md_stat.busy && out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (act_reg == mseu_pkg::ACT_MUL)
                    begin
                        emit_index = dest_reg;
                        emit_value = alu_val;
                        emit_wrote = dest_ok;
                        rf_wr_en   = dest_ok;
                    end
                    else
                    begin
                        hi_next = md_hi;
                        lo_next = md_lo;
                    end
                end
            end
            S_DUMP_RD:
            begin
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_index = IW'(cnt_reg);
                    emit_value = a_ok_reg ? rd_a_reg : '0;
                    emit_wrote = 1'b1;
                    emit_last  = (cnt_reg == LAST_ADDR);
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = (cnt_reg == LAST_ADDR) ? S_IDLE : S_DUMP_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            rf_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            if (rf_wr_en)
            begin
                rf_valid_reg[rf_wr_addr] <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg  <= action;
            dest_reg <= dest_index;
            imm_reg  <= immediate;
            a_ok_reg <= ({1'b0, src_a_index} < NREG_L) && rf_valid_reg[src_a_index[AW-1:0]];
            b_ok_reg <= ({1'b0, src_b_index} < NREG_L) && rf_valid_reg[src_b_index[AW-1:0]];
        end
        else if (state_reg == S_DUMP_RD)
        begin
            a_ok_reg <= rf_valid_reg[cnt_reg];
        end
        if (emit)
        begin
            res_index_reg <= emit_index;
            res_value_reg <= emit_value;
            res_wrote_reg <= emit_wrote;
            res_hi_reg    <= hi_next;
            res_lo_reg    <= lo_next;
            res_dz_reg    <= emit_dz;
            res_last_reg  <= emit_last;
        end
    end

    mseu_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (md_ctrl),
        .op_a  (a_val),
        .op_b  (b_val),
        .stat  (md_stat),
        .hi    (md_hi),
        .lo    (md_lo)
    );

    assign out_valid      = out_valid_reg;
    assign result_index   = res_index_reg;
    assign result_value   = res_value_reg;
    assign wrote_register = res_wrote_reg;
    assign hi_value       = res_hi_reg;
    assign lo_value       = res_lo_reg;
    assign divide_by_zero = res_dz_reg;
    assign last           = res_last_reg;

    a_ready_only_when_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !md_stat.busy)
        else $error("new request could be accepted while the shared unit was busy");

    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr_en |-> (emit && emit_wrote))
        else $error("register file written without a reported result");

    a_dz_never_writes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_dz_reg && res_wrote_reg))
        else $error("divide by zero reported together with a register write");

    a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP_OUT && out_free && cnt_reg == LAST_ADDR) |=> state_reg == S_IDLE)
        else $error("dump did not finish after the final register");

endmodule

`default_nettype wire

/* hdl/mseu_muldiv.sv */
`default_nettype none

module mseu_muldiv (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mseu_pkg::md_ctrl_t             ctrl,
    input  wire logic [mseu_pkg::DATA_W-1:0]    op_a,
    input  wire logic [mseu_pkg::DATA_W-1:0]    op_b,
    output mseu_pkg::md_stat_t                  stat,
    output logic      [mseu_pkg::DATA_W-1:0]    hi,
    output logic      [mseu_pkg::DATA_W-1:0]    lo
);

    localparam int DW = mseu_pkg::DATA_W;
    localparam int CW = $clog2(DW);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_RUN  = 2'd1;
    localparam logic [1:0] MD_FIX  = 2'd2;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [DW-1:0] acc_hi_reg;
    logic [DW-1:0] acc_lo_reg;
    logic [DW-1:0] opnd_reg;
    logic          is_div_reg;
    logic          neg_q_reg;
    logic          neg_r_reg;

    logic [DW-1:0] mag_a;
    logic [DW-1:0] mag_b;
    logic [DW:0]   add_x;
    logic [DW:0]   add_y;
    logic [DW+1:0] sum;
    logic [2*DW-1:0] prod_neg;

    assign mag_a = op_a[DW-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b = op_b[DW-1] ? (~op_b + 1'b1) : op_b;

    // The single adder serves both the shift-add multiply and the restoring divide.
    always_comb
    begin
        if (is_div_reg)
        begin
            add_x = {acc_hi_reg, acc_lo_reg[DW-1]};
            add_y = ~{1'b0, opnd_reg};
        end
        else
        begin
            add_x = {1'b0, acc_hi_reg};
            add_y = acc_lo_reg[0] ? {1'b0, opnd_reg} : '0;
        end
        sum = {1'b0, add_x} + {1'b0, add_y} + {{(DW+1){1'b0}}, is_div_reg};
    end

    assign prod_neg = ~{acc_hi_reg, acc_lo_reg} + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = MD_RUN;
                    cnt_next   = '0;
                end
            end
            MD_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MD_IDLE && ctrl.start)
        begin
            is_div_reg <= ctrl.is_div;
            neg_q_reg  <= op_a[DW-1] ^ op_b[DW-1];
            neg_r_reg  <= op_a[DW-1];
            opnd_reg   <= mag_b;
            acc_hi_reg <= '0;
            acc_lo_reg <= mag_a;
        end
        else if (state_reg == MD_RUN)
        begin
            if (is_div_reg)
            begin
                if (sum[DW+1])
                begin
                    acc_hi_reg <= sum[DW-1:0];
                    acc_lo_reg <= {acc_lo_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    acc_hi_reg <= add_x[DW-1:0];
                    acc_lo_reg <= {acc_lo_reg[DW-2:0], 1'b0};
                end
            end
            else
            begin
                acc_hi_reg <= sum[DW:1];
                acc_lo_reg <= {sum[0], acc_lo_reg[DW-1:1]};
            end
        end
        else if (state_reg == MD_FIX)
        begin
            if (is_div_reg)
            begin
                if (neg_q_reg)
                begin
                    acc_lo_reg <= ~acc_lo_reg + 1'b1;
                end
                if (neg_r_reg)
                begin
                    acc_hi_reg <= ~acc_hi_reg + 1'b1;
                end
            end
            else if (neg_q_reg)
            begin
                acc_hi_reg <= prod_neg[2*DW-1:DW];
                acc_lo_reg <= prod_neg[DW-1:0];
            end
        end
    end

    assign stat.busy = (state_reg != MD_IDLE);
    assign hi        = acc_hi_reg;
    assign lo        = acc_lo_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == MD_IDLE)
        else $error("request started while the unit was busy");

    a_no_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.start && ctrl.is_div) |-> op_b != '0)
        else $error("divide started with a zero divisor");

    a_run_ends_in_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == MD_RUN && cnt_reg == CW'(DW - 1)) |=> state_reg == MD_FIX)
        else $error("iteration count overran");

endmodule

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;

    localparam int DATA_W      = mseu_pkg::DATA_W;
    localparam int IDX_W       = mseu_pkg::IDX_W;
    localparam int ACT_W       = mseu_pkg::ACT_W;
    localparam int N_REGS      = mseu_pkg::NUM_REGS_DEF;
    localparam int RANDOM_REQS = 430;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] value;
        logic              wrote;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic              dz;
        logic              last;
    } exec_result_t;

    class execute_scoreboard;
        logic [DATA_W-1:0] regs [N_REGS];
        logic [DATA_W-1:0] hi_word;
        logic [DATA_W-1:0] lo_word;
        exec_result_t      pending_results [$];
        int                mismatches;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            hi_word    = '0;
            lo_word    = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_result(exec_result_t r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function logic [DATA_W-1:0] read_reg(logic [IDX_W-1:0] idx);
            if (idx < N_REGS)
                return regs[idx];
            return '0;
        endfunction

        function void execute_request(mseu_pkg::action_t act, logic [IDX_W-1:0] rd,
                                      logic [IDX_W-1:0] ra, logic [IDX_W-1:0] rb,
                                      logic [DATA_W-1:0] imm);
            logic [DATA_W-1:0] a;
            logic [DATA_W-1:0] b;
            logic [DATA_W-1:0] v;
            bit                writes;
            bit                dz;
            longint            prod;
            longint            num;
            longint            den;
            longint            quo;
            longint            rem;
            exec_result_t      r;
            a      = read_reg(ra);
            b      = read_reg(rb);
            v      = '0;
            writes = 1;
            dz     = 0;
            case (act)
                mseu_pkg::ACT_LI:    v = imm;
                mseu_pkg::ACT_ADD,
                mseu_pkg::ACT_ADDU:  v = a + b;
                mseu_pkg::ACT_SUB,
                mseu_pkg::ACT_SUBU:  v = a - b;
                mseu_pkg::ACT_ADDI,
                mseu_pkg::ACT_ADDIU: v = a + imm;
                mseu_pkg::ACT_MUL:   v = a * b;
                mseu_pkg::ACT_MULT:
                begin
                    prod    = longint'($signed(a)) * longint'($signed(b));
                    hi_word = prod[63:32];
                    lo_word = prod[31:0];
                    writes  = 0;
                end
                mseu_pkg::ACT_DIV:
                begin
                    writes = 0;
                    if (b == '0)
                    begin
                        dz = 1;
                    end
                    else
                    begin
                        num     = longint'($signed(a));
                        den     = longint'($signed(b));
                        quo     = num / den;
                        rem     = num % den;
                        lo_word = quo[31:0];
                        hi_word = rem[31:0];
                    end
                end
                mseu_pkg::ACT_AND:    v = a & b;
                mseu_pkg::ACT_OR_REG: v = a | b;
                mseu_pkg::ACT_OR_IMM: v = a | imm;
                mseu_pkg::ACT_ANDI:   v = a & imm;
                mseu_pkg::ACT_SLL:    v = a << imm[4:0];
                mseu_pkg::ACT_SRL:    v = a >> imm[4:0];
                mseu_pkg::ACT_XOR:    v = a ^ b;
                mseu_pkg::ACT_DUMP:
                begin
                    for (int i = 0; i < N_REGS; i++)
                    begin
                        r = '{index: idx_t'(i), value: regs[i], wrote: 1'b1,
                              hi: hi_word, lo: lo_word, dz: 1'b0,
                              last: (i == N_REGS - 1)};
                        note_result(r);
                    end
                    return;
                end
                default:    writes = 0;
            endcase
            if (!writes)
            begin
                r = '{index: '0, value: '0, wrote: 1'b0, hi: hi_word, lo: lo_word,
                      dz: dz, last: 1'b1};
            end
            else
            begin
                if (rd < N_REGS)
                    regs[rd] = v;
                r = '{index: rd, value: v, wrote: (rd < N_REGS), hi: hi_word,
                      lo: lo_word, dz: 1'b0, last: 1'b1};
            end
            note_result(r);
        endfunction

        function void compare_result(exec_result_t got);
            exec_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: idx=%0d val=%h wr=%b hi=%h lo=%h dz=%b last=%b",
                             got.index, got.value, got.wrote, got.hi, got.lo, got.dz,
                             got.last);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch exp: idx=%0d val=%h wr=%b hi=%h lo=%h dz=%b last=%b",
                             want.index, want.value, want.wrote, want.hi, want.lo, want.dz,
                             want.last);
                    $display("         got: idx=%0d val=%h wr=%b hi=%h lo=%h dz=%b last=%b",
                             got.index, got.value, got.wrote, got.hi, got.lo, got.dz,
                             got.last);
                end
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         dest_index;
    logic [IDX_W-1:0]         src_a_index;
    logic [IDX_W-1:0]         src_b_index;
    logic signed [DATA_W-1:0] immediate;
    logic                     out_valid;
    logic                     out_ready;
    logic [IDX_W-1:0]         result_index;
    logic signed [DATA_W-1:0] result_value;
    logic                     wrote_register;
    logic signed [DATA_W-1:0] hi_value;
    logic signed [DATA_W-1:0] lo_value;
    logic                     divide_by_zero;
    logic                     last;

    bit                calm = 0;
    execute_scoreboard sb = new();

    mips_subset_execute_unit #(
        .NUM_REGS(N_REGS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .dest_index    (dest_index),
        .src_a_index   (src_a_index),
        .src_b_index   (src_b_index),
        .immediate     (immediate),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_index  (result_index),
        .result_value  (result_value),
        .wrote_register(wrote_register),
        .hi_value      (hi_value),
        .lo_value      (lo_value),
        .divide_by_zero(divide_by_zero),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic logic [DATA_W-1:0] rand_imm();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return '0;
        if (r < 22)
        begin
            case ($urandom_range(0, 4))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'hffff_ffff;
                3:       return 32'h0000_0001;
                default: return $urandom_range(0, 63);
            endcase
        end
        if (r < 40)
            return $urandom_range(0, 40) - 20;
        return $urandom();
    endfunction

    task automatic send_request(input mseu_pkg::action_t act, input logic [IDX_W-1:0] rd,
                                input logic [IDX_W-1:0] ra, input logic [IDX_W-1:0] rb,
                                input logic [DATA_W-1:0] imm);
        @(negedge clk);
        action      = act;
        dest_index  = rd;
        src_a_index = ra;
        src_b_index = rb;
        immediate   = imm;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.execute_request(act, rd, ra, rb, imm);
    endtask

    task automatic pause_sender();
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        int                r;
        mseu_pkg::action_t act;
        r = $urandom_range(0, 99);
        if (r < 2)
            act = mseu_pkg::ACT_DUMP;
        else if (r < 5)
            act = mseu_pkg::action_t'($urandom_range(mseu_pkg::ACT_DUMP + 1, 2 ** ACT_W - 1));
        else if (r < 22)
            act = mseu_pkg::ACT_LI;
        else
            act = mseu_pkg::action_t'($urandom_range(mseu_pkg::ACT_LI, mseu_pkg::ACT_XOR));
        send_request(act, idx_t'($urandom()), idx_t'($urandom()), idx_t'($urandom()),
                     rand_imm());
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.compare_result('{index: result_index, value: result_value,
                                wrote: wrote_register, hi: hi_value, lo: lo_value,
                                dz: divide_by_zero, last: last});
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                out_ready = 1'b0;
                repeat (stall - 1)
                    @(negedge clk);
            end
            @(negedge clk);
            out_ready = 1'b1;
            repeat ($urandom_range(0, 8))
                @(negedge clk);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = '0;
        dest_index  = '0;
        src_a_index = '0;
        src_b_index = '0;
        immediate   = '0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;

        // Extremes, wrapping arithmetic, the division corner cases, undefined actions and a dump.
        send_request(mseu_pkg::ACT_LI,     5'd1,  5'd0,  5'd0,  32'h7fff_ffff);
        send_request(mseu_pkg::ACT_LI,     5'd2,  5'd0,  5'd0,  32'h8000_0000);
        send_request(mseu_pkg::ACT_LI,     5'd3,  5'd0,  5'd0,  32'hffff_ffff);
        send_request(mseu_pkg::ACT_LI,     5'd31, 5'd0,  5'd0,  -32'sd7);
        send_request(mseu_pkg::ACT_ADD,    5'd4,  5'd1,  5'd1,  32'h0);
        send_request(mseu_pkg::ACT_SUB,    5'd5,  5'd2,  5'd31, 32'h0);
        send_request(mseu_pkg::ACT_ADDI,   5'd6,  5'd1,  5'd0,  32'h1);
        send_request(mseu_pkg::ACT_ADDU,   5'd7,  5'd3,  5'd3,  32'h0);
        send_request(mseu_pkg::ACT_ADDIU,  5'd8,  5'd2,  5'd0,  32'hffff_ffff);
        send_request(mseu_pkg::ACT_SUBU,   5'd9,  5'd0,  5'd31, 32'h0);
        send_request(mseu_pkg::ACT_MUL,    5'd10, 5'd1,  5'd1,  32'h0);
        send_request(mseu_pkg::ACT_MULT,   5'd0,  5'd2,  5'd3,  32'h0);
        send_request(mseu_pkg::ACT_DIV,    5'd0,  5'd2,  5'd3,  32'h0);
        send_request(mseu_pkg::ACT_DIV,    5'd0,  5'd1,  5'd0,  32'h0);
        send_request(mseu_pkg::ACT_DIV,    5'd0,  5'd2,  5'd31, 32'h0);
        send_request(mseu_pkg::ACT_AND,    5'd11, 5'd1,  5'd3,  32'h0);
        send_request(mseu_pkg::ACT_OR_REG, 5'd12, 5'd2,  5'd31, 32'h0);
        send_request(mseu_pkg::ACT_OR_IMM, 5'd13, 5'd0,  5'd0,  32'hffff_0000);
        send_request(mseu_pkg::ACT_ANDI,   5'd14, 5'd3,  5'd0,  32'h0000_0f0f);
        send_request(mseu_pkg::ACT_SLL,    5'd15, 5'd3,  5'd0,  32'd33);
        send_request(mseu_pkg::ACT_SRL,    5'd16, 5'd2,  5'd0,  32'hffff_ffff);
        send_request(mseu_pkg::ACT_XOR,    5'd17, 5'd1,  5'd3,  32'h0);
        send_request(mseu_pkg::action_t'(mseu_pkg::ACT_DUMP + 1), 5'd18, 5'd1, 5'd2,
                     32'h1234_5678);
        send_request(mseu_pkg::action_t'(2 ** ACT_W - 1), 5'd19, 5'd3, 5'd4, 32'hffff_ffff);
        send_request(mseu_pkg::ACT_DUMP,   5'd0,  5'd0,  5'd0,  32'h0);

        wait_for_drain();

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            calm = (n >= 150 && n < 220);
            if (n == 300)
                wait_for_drain();
            random_request();
            pause_sender();
        end

        wait_for_drain();
        repeat (40)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
